// File: rtl/core/hbkps2_pkg.sv
// Shared types, codes and lookup tables for the HID boot keyboard to PS/2 Set-1 translator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package hbkps2_pkg;

   typedef enum logic {
      OP_REPORT = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   // One translated event; pending marks a slot of the event vector that must go out.
   typedef struct packed {
      logic       pending;
      logic [6:0] scancode;
      logic       key_down;
      logic       extended;
   } evt_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int MOD_COUNT   = 8;
   localparam int MAX_KEYS    = 6;

   localparam int ROM_DEPTH = 'h62;
   localparam logic [7:0] ROM_BASE  = 8'h04;
   localparam logic [7:0] ROM_LIMIT = ROM_BASE + 8'(ROM_DEPTH);

   // Entry: bit 7 = E0 extended, bits 6..0 = make code (zero = unmapped).
   localparam logic [7:0] KEY_ROM [ROM_DEPTH] = '{
      8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23,
      8'h17, 8'h24, 8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19,
      8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
      8'h15, 8'h2C, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
      8'h08, 8'h09, 8'h0A, 8'h0B, 8'h1C, 8'h01, 8'h0E, 8'h0F,
      8'h39, 8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h00, 8'h27,
      8'h28, 8'h29, 8'h33, 8'h34, 8'h35, 8'h3A, 8'h3B, 8'h3C,
      8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44,
      8'h57, 8'h58, 8'h00, 8'h46, 8'h00, 8'hD2, 8'hC7, 8'hC9,
      8'hD3, 8'hCF, 8'hD1, 8'hCD, 8'hCB, 8'hD0, 8'hC8, 8'h45,
      8'hB5, 8'h37, 8'h4A, 8'h4E, 8'h9C, 8'h4F, 8'h50, 8'h51,
      8'h4B, 8'h4C, 8'h4D, 8'h47, 8'h48, 8'h49, 8'h52, 8'h53,
      8'h56, 8'h00
   };

   // L-Ctrl, L-Shift, L-Alt, L-GUI, R-Ctrl, R-Shift, R-Alt, R-GUI
   localparam logic [7:0] MOD_ROM [MOD_COUNT] = '{
      8'h1D, 8'h2A, 8'h38, 8'hDB, 8'h9D, 8'h36, 8'hB8, 8'hDC
   };

   function automatic logic [7:0] key_lookup(input logic [7:0] code);
      logic [7:0] entry;
      entry = 8'h00;
      if (code >= ROM_BASE && code < ROM_LIMIT) begin
         entry = KEY_ROM[7'(code - ROM_BASE)];
      end
      return entry;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/hbkps2_req_if.sv
// Report channel: valid/ready handshake carrying one keyboard snapshot per item.
// Depends on hbkps2_pkg for shared widths.
`default_nettype none
interface hbkps2_req_if;
   import hbkps2_pkg::*;

   logic       valid;
   logic       ready;
   logic       opcode;
   logic [2:0] slot;
   logic [7:0] modifier_bits;
   logic [7:0] key_code_0;
   logic [7:0] key_code_1;
   logic [7:0] key_code_2;
   logic [7:0] key_code_3;
   logic [7:0] key_code_4;
   logic [7:0] key_code_5;

   modport source (
      output valid, opcode, slot, modifier_bits,
      output key_code_0, key_code_1, key_code_2, key_code_3, key_code_4, key_code_5,
      input  ready
   );

   modport sink (
      input  valid, opcode, slot, modifier_bits,
      input  key_code_0, key_code_1, key_code_2, key_code_3, key_code_4, key_code_5,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/core/hbkps2_rsp_if.sv
// Event channel: valid/ready handshake carrying one PS/2 Set-1 event per item.
// Depends on hbkps2_pkg for shared widths.
`default_nettype none
interface hbkps2_rsp_if;
   import hbkps2_pkg::*;

   logic       valid;
   logic       ready;
   logic [6:0] scancode;
   logic       key_down;
   logic       extended;
   logic       last_event;

   modport source (
      output valid, scancode, key_down, extended, last_event,
      input  ready
   );

   modport sink (
      input  valid, scancode, key_down, extended, last_event,
      output ready
   );
endinterface
`default_nettype wire

// File: rtl/core/hbkps2_front.sv
// Front end: accepts reports, diffs them against the per-slot history and
// pushes one vector of pending events into the queue. Uses hbkps2_pkg, hbkps2_req_if.
`default_nettype none
module hbkps2_front #(
   parameter int SLOT_COUNT      = 8,
   parameter int KEYS_PER_REPORT = 6
) (
   input  logic                                          clock,
   input  logic                                          reset,
   hbkps2_req_if.sink                                    req_port,
   output logic                                          q_push,
   output hbkps2_pkg::evt_type [8+2*KEYS_PER_REPORT-1:0] q_data,
   input  hbkps2_pkg::q_stat_type                        q_stat
);
   import hbkps2_pkg::*;

   localparam int SLOT_DEPTH = (SLOT_COUNT < 8) ? SLOT_COUNT : 8;
   localparam int SLOT_IDX_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam int EVT_COUNT  = MOD_COUNT + 2 * KEYS_PER_REPORT;

   logic [7:0]                          hist_mods_ff [SLOT_DEPTH];
   logic [KEYS_PER_REPORT-1:0][7:0]     hist_keys_ff [SLOT_DEPTH];
   logic [7:0]                          hist_mods_in;
   logic [KEYS_PER_REPORT-1:0][7:0]     hist_keys_in;
   logic                                hist_we;

   logic                                accept;
   logic                                slot_ok;
   logic [SLOT_IDX_W-1:0]               idx;
   logic [MAX_KEYS-1:0][7:0]            all_keys;
   logic [KEYS_PER_REPORT-1:0][7:0]     new_keys;
   logic [KEYS_PER_REPORT-1:0][7:0]     old_keys;
   logic [7:0]                          old_mods;
   logic [7:0]                          changed;
   logic [KEYS_PER_REPORT-1:0]          new_in_old;
   logic [KEYS_PER_REPORT-1:0]          old_in_new;
   evt_type [EVT_COUNT-1:0]             events;
   logic [EVT_COUNT-1:0]                pend_mask;

   assign req_port.ready = !q_stat.full;
   assign accept  = req_port.valid && req_port.ready;
   assign slot_ok = int'(req_port.slot) < SLOT_COUNT;
   assign idx     = req_port.slot[SLOT_IDX_W-1:0];

   assign all_keys = {req_port.key_code_5, req_port.key_code_4, req_port.key_code_3,
                      req_port.key_code_2, req_port.key_code_1, req_port.key_code_0};
   assign new_keys = all_keys[KEYS_PER_REPORT-1:0];
   assign old_keys = hist_keys_ff[idx];
   assign old_mods = hist_mods_ff[idx];
   assign changed  = old_mods ^ req_port.modifier_bits;

   always_comb begin
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
         new_in_old[i] = 1'b0;
         old_in_new[i] = 1'b0;
         for (int j = 0; j < KEYS_PER_REPORT; j++) begin
            new_in_old[i] = new_in_old[i] | (new_keys[i] == old_keys[j]);
            old_in_new[i] = old_in_new[i] | (old_keys[i] == new_keys[j]);
         end
      end
   end

   // Modifiers first, then presses in report order, then releases in stored order.
   always_comb begin
      logic [7:0] entry;
      for (int i = 0; i < MOD_COUNT; i++) begin
         events[i].pending  = changed[i];
         events[i].scancode = MOD_ROM[i][6:0];
         events[i].key_down = req_port.modifier_bits[i];
         events[i].extended = MOD_ROM[i][7];
      end
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
         entry = key_lookup(new_keys[i]);
         events[MOD_COUNT+i].pending  = (new_keys[i] != 8'h00) && !new_in_old[i]
                                        && (entry[6:0] != 7'h00);
         events[MOD_COUNT+i].scancode = entry[6:0];
         events[MOD_COUNT+i].key_down = 1'b1;
         events[MOD_COUNT+i].extended = entry[7];
      end
      for (int i = 0; i < KEYS_PER_REPORT; i++) begin
         entry = key_lookup(old_keys[i]);
         events[MOD_COUNT+KEYS_PER_REPORT+i].pending  = (old_keys[i] != 8'h00)
                                                        && !old_in_new[i]
                                                        && (entry[6:0] != 7'h00);
         events[MOD_COUNT+KEYS_PER_REPORT+i].scancode = entry[6:0];
         events[MOD_COUNT+KEYS_PER_REPORT+i].key_down = 1'b0;
         events[MOD_COUNT+KEYS_PER_REPORT+i].extended = entry[7];
      end
   end

   always_comb begin
      for (int i = 0; i < EVT_COUNT; i++) begin
         pend_mask[i] = events[i].pending;
      end
   end

   // Drop reports that produce nothing; the back end never sees an empty vector.
   assign q_push = accept && slot_ok && (req_port.opcode == OP_REPORT) && (|pend_mask);
   assign q_data = events;

   assign hist_we      = accept && slot_ok;
   assign hist_mods_in = (req_port.opcode == OP_CLEAR) ? 8'h00 : req_port.modifier_bits;
   assign hist_keys_in = (req_port.opcode == OP_CLEAR) ? '0 : new_keys;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOT_DEPTH; s++) begin
            hist_mods_ff[s] <= 8'h00;
            hist_keys_ff[s] <= '0;
         end
      end else if (hist_we) begin
         hist_mods_ff[idx] <= hist_mods_in;
         hist_keys_ff[idx] <= hist_keys_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_clear_zeroes_slot: assert property (@(posedge clock) disable iff (reset)
      (accept && slot_ok && req_port.opcode == OP_CLEAR)
      |=> (hist_mods_ff[$past(idx)] == 8'h00 && hist_keys_ff[$past(idx)] == '0))
      else $error("slot history not cleared");
`endif

endmodule
`default_nettype wire

// File: rtl/core/hbkps2_queue.sv
// Short register queue between the front end and the back end.
// Uses hbkps2_pkg for the status struct.
`default_nettype none
module hbkps2_queue #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       rd_data,
   output hbkps2_pkg::q_stat_type q_stat
);
   import hbkps2_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign rd_data      = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_stat.full || pop))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// File: rtl/core/hbkps2_back.sv
// Back end: walks a queued event vector lowest slot first into a registered output
// stage, one event per cycle while it is free. Uses hbkps2_pkg, hbkps2_rsp_if.
`default_nettype none
module hbkps2_back #(
   parameter int EVT_COUNT = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hbkps2_pkg::evt_type [EVT_COUNT-1:0] q_data,
   input  hbkps2_pkg::q_stat_type              q_stat,
   output logic                                q_pop,
   hbkps2_rsp_if.source                        rsp_port
);
   import hbkps2_pkg::*;

   evt_type [EVT_COUNT-1:0] work_ff, work_in;
   logic [EVT_COUNT-1:0]    work_mask;
   logic [EVT_COUNT-1:0]    low_oh;
   logic [EVT_COUNT-1:0]    rest;
   logic                    work_busy;
   logic                    out_free;
   logic                    take;
   logic                    final_take;
   evt_type                 pick;

   logic       rsp_valid_ff, rsp_valid_in;
   evt_type    rsp_evt_ff, rsp_evt_in;
   logic       rsp_last_ff, rsp_last_in;

   always_comb begin
      for (int i = 0; i < EVT_COUNT; i++) begin
         work_mask[i] = work_ff[i].pending;
      end
   end

   assign low_oh     = work_mask & (~work_mask + EVT_COUNT'(1));
   assign rest       = work_mask & ~low_oh;
   assign work_busy  = |work_mask;
   assign out_free   = !rsp_valid_ff || rsp_port.ready;
   assign take       = out_free && work_busy;
   assign final_take = take && (rest == '0);
   assign q_pop      = !q_stat.empty && (!work_busy || final_take);

   always_comb begin
      pick = '0;
      for (int i = 0; i < EVT_COUNT; i++) begin
         if (low_oh[i]) begin
            pick = evt_type'(pick | work_ff[i]);
         end
      end
   end

   always_comb begin
      work_in = work_ff;
      if (q_pop) begin
         work_in = q_data;
      end else if (take) begin
         for (int i = 0; i < EVT_COUNT; i++) begin
            work_in[i].pending = work_ff[i].pending & ~low_oh[i];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_evt_in   = rsp_evt_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (take) begin
         rsp_valid_in = 1'b1;
         rsp_evt_in   = pick;
         rsp_last_in  = final_take;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < EVT_COUNT; i++) begin
            work_ff[i].pending <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         work_ff      <= work_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_evt_ff  <= rsp_evt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.scancode   = rsp_evt_ff.scancode;
   assign rsp_port.key_down   = rsp_evt_ff.key_down;
   assign rsp_port.extended   = rsp_evt_ff.extended;
   assign rsp_port.last_event = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_pop_not_empty_vector: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> work_busy)
      else $error("loaded an event vector with nothing pending");
   a_last_drains_work: assert property (@(posedge clock) disable iff (reset)
      (final_take && !q_pop) |=> !work_busy)
      else $error("work left after last event");
`endif

endmodule
`default_nettype wire

// File: rtl/core/hid_boot_kbd_to_ps2_set1_top.sv
// HID boot keyboard to PS/2 Set-1 translator, top level.
// A report's events pass the queue slot, the work register and the output register.
// Throughput: one event per cycle while the output sink is ready; a report yields
// up to 20 events, and a report with none is dropped at the input.
// The front end keeps taking reports while the 2-entry event queue has room.
// Synchronous active-high reset clears slot history, queue and output valid at once.
`default_nettype none
module hid_boot_kbd_to_ps2_set1_top #(
   parameter int SLOT_COUNT      = 8,
   parameter int KEYS_PER_REPORT = 6
) (
   input  logic         clock,
   input  logic         reset,
   hbkps2_req_if.sink   req_port,
   hbkps2_rsp_if.source rsp_port
);
   import hbkps2_pkg::*;

   localparam int EVT_COUNT = MOD_COUNT + 2 * KEYS_PER_REPORT;
   localparam int Q_WIDTH   = EVT_COUNT * $bits(evt_type);

   logic                    q_push;
   logic                    q_pop;
   evt_type [EVT_COUNT-1:0] q_wr_data;
   evt_type [EVT_COUNT-1:0] q_rd_data;
   q_stat_type              q_stat;

   hbkps2_front #(
      .SLOT_COUNT      (SLOT_COUNT),
      .KEYS_PER_REPORT (KEYS_PER_REPORT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .q_push   (q_push),
      .q_data   (q_wr_data),
      .q_stat   (q_stat)
   );

   hbkps2_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .q_stat  (q_stat)
   );

   hbkps2_back #(
      .EVT_COUNT (EVT_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_rd_data),
      .q_stat   (q_stat),
      .q_pop    (q_pop),
      .rsp_port (rsp_port)
   );

endmodule
`default_nettype wire
